/* src/fat12_cluster_chain_sector_walker_macros.svh */
// ----------------------------------------------------------------------------
// FAT12 walker assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_SECTOR_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_SECTOR_WALKER_MACROS_SVH

// same-cycle implication
`define FCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/fat12ccw_pkg.sv */
// ----------------------------------------------------------------------------
// FAT12 walker package
// Shared widths, codes and the table port bundles.
// ----------------------------------------------------------------------------
package fat12ccw_pkg;

    localparam int TABLE_BYTES_DEF = 8192;
    localparam int TABLE_INDEX_W   = 13;
    localparam int CLUSTER_W       = 12;
    localparam int LBA_W           = 32;

    localparam logic [CLUSTER_W-1:0] CHAIN_END_MIN = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] CLUSTER_MASK  = 12'hFFF;
    localparam logic [LBA_W-1:0]     FIRST_DATA_CL = 32'd2;

    // commands
    localparam logic [1:0] CMD_WRITE_BYTE = 2'd0;
    localparam logic [1:0] CMD_OPEN_FILE  = 2'd1;
    localparam logic [1:0] CMD_OPEN_ROOT  = 2'd2;
    localparam logic [1:0] CMD_ADVANCE    = 2'd3;

    // register indexes
    localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd0;
    localparam logic [1:0] REG_DATA_START_LBA      = 2'd1;
    localparam logic [1:0] REG_ROOT_DIR_LBA        = 2'd2;

    typedef struct packed {
        logic                     en;
        logic [TABLE_INDEX_W-1:0] index;
        logic [7:0]               data;
    } tbl_wr_t;

    typedef struct packed {
        logic                     en;
        logic [TABLE_INDEX_W-1:0] at;   // byte address of the low byte
    } tbl_rd_t;

endpackage

/* src/fat12ccw_table.sv */
// ----------------------------------------------------------------------------
// FAT12 walker allocation table
// Byte-wide table split into even and odd banks so one read returns the
// little-endian 16-bit word at any byte address. Bytes past the end read 0.
// ----------------------------------------------------------------------------
module fat12ccw_table #(
    parameter int TABLE_BYTES = fat12ccw_pkg::TABLE_BYTES_DEF
) (
    input  logic                  aclk,
    input  fat12ccw_pkg::tbl_wr_t wr,
    input  fat12ccw_pkg::tbl_rd_t rd,
    output logic [15:0]           rd_word
);
    import fat12ccw_pkg::*;

    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam logic [TABLE_INDEX_W:0] LIMIT = (TABLE_INDEX_W + 1)'(TABLE_BYTES);

    logic [7:0] bank_even [BANK_DEPTH];
    logic [7:0] bank_odd  [BANK_DEPTH];

    logic                     wr_ok;
    logic [TABLE_INDEX_W:0]   at_hi;
    logic                     lo_ok;
    logic                     hi_ok;
    logic                     even_ok;
    logic                     odd_ok;
    logic [TABLE_INDEX_W-2:0] even_idx;
    logic [TABLE_INDEX_W-2:0] odd_idx;
    logic [TABLE_INDEX_W-2:0] wr_idx;

    logic [7:0] even_q;
    logic [7:0] odd_q;
    logic       even_ok_q;
    logic       odd_ok_q;
    logic       swap_q;
    logic [7:0] even_b;
    logic [7:0] odd_b;

    assign wr_ok  = {1'b0, wr.index} < LIMIT;
    assign wr_idx = wr.index[TABLE_INDEX_W-1:1];

    assign at_hi    = {1'b0, rd.at} + (TABLE_INDEX_W + 1)'(1);
    assign lo_ok    = {1'b0, rd.at} < LIMIT;
    assign hi_ok    = at_hi < LIMIT;
    // odd address: low byte in the odd bank, high byte in the next even row
    assign even_idx = rd.at[0] ? at_hi[TABLE_INDEX_W-1:1] : rd.at[TABLE_INDEX_W-1:1];
    assign odd_idx  = rd.at[TABLE_INDEX_W-1:1];
    assign even_ok  = rd.at[0] ? hi_ok : lo_ok;
    assign odd_ok   = rd.at[0] ? lo_ok : hi_ok;

    always_ff @(posedge aclk) begin
        if (wr.en && wr_ok && !wr.index[0]) begin
            bank_even[wr_idx[AW-1:0]] <= wr.data;
        end
        if (rd.en && even_ok) begin
            even_q <= bank_even[even_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr_ok && wr.index[0]) begin
            bank_odd[wr_idx[AW-1:0]] <= wr.data;
        end
        if (rd.en && odd_ok) begin
            odd_q <= bank_odd[odd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            even_ok_q <= even_ok;
            odd_ok_q  <= odd_ok;
            swap_q    <= rd.at[0];
        end
    end

    assign even_b  = even_ok_q ? even_q : 8'd0;
    assign odd_b   = odd_ok_q  ? odd_q  : 8'd0;
    assign rd_word = swap_q ? {even_b, odd_b} : {odd_b, even_b};

endmodule

/* src/fat12_cluster_chain_sector_walker.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain sector walker
// Holds a FAT12 allocation table and walks a file's cluster chain, one
// sector LBA per command.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one command per transaction (write table byte, open file,
//   open root directory, advance one sector). m_* channel: exactly one
//   result transaction per command (read_valid, sector_lba, chain_end).
//   cfg_*: plain register writes, only while no command is in flight.
// Result path, accept to result on m_*:
//   table write, open root, root advance: straight to S_DONE
//   open file, advance inside a cluster: S_MUL, S_ADD (multiply, add)
//   advance across a cluster boundary: S_LOOKUP (table read), S_MUL, S_ADD
//   chain end: straight to S_DONE, or through S_LOOKUP after a table read
// Flow: one command at a time; s_ready is low from accept until the
//   result moves to the output register, so none is taken while busy.
// Reset: walker state and registers go to their defaults (sectors per
//   cluster 1); the table is not cleared and must be written before use.
// Stall: a finished result waits in a holding register while the output
//   register is still full; s_ready stays low until it moves on.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_sector_walker #(
    parameter int TABLE_BYTES = fat12ccw_pkg::TABLE_BYTES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_index,
    input  logic [fat12ccw_pkg::LBA_W-1:0]       cfg_wdata,
    // command channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic [fat12ccw_pkg::TABLE_INDEX_W-1:0] s_table_index,
    input  logic [7:0]                           s_table_byte,
    input  logic [fat12ccw_pkg::CLUSTER_W-1:0]   s_first_cluster,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_read_valid,
    output logic [fat12ccw_pkg::LBA_W-1:0]       m_sector_lba,
    output logic                                 m_chain_end
);
    import fat12ccw_pkg::*;

    `include "fat12_cluster_chain_sector_walker_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;

    // configuration
    logic [7:0]             spc_reg, spc_next;
    logic [LBA_W-1:0]       data_start_reg, data_start_next;
    logic [LBA_W-1:0]       root_dir_reg, root_dir_next;

    // walker state
    logic [CLUSTER_W-1:0]   cluster_reg, cluster_next;
    logic [7:0]             sic_reg, sic_next;
    logic                   root_mode_reg, root_mode_next;
    logic [LBA_W-1:0]       root_lba_reg, root_lba_next;

    // datapath
    logic [LBA_W-1:0]       prod_reg, prod_next;
    logic                   res_valid_reg, res_valid_next;
    logic [LBA_W-1:0]       res_lba_reg, res_lba_next;
    logic                   res_end_reg, res_end_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic                   m_read_valid_reg, m_read_valid_next;
    logic [LBA_W-1:0]       m_lba_reg, m_lba_next;
    logic                   m_end_reg, m_end_next;

    tbl_wr_t                tbl_wr;
    tbl_rd_t                tbl_rd;
    logic [15:0]            tbl_word;

    logic                   accept;
    logic [7:0]             sic_inc;
    logic [CLUSTER_W-1:0]   next_cl;
    logic [LBA_W-1:0]       cl_off;
    logic [LBA_W-1:0]       prod_full;
    logic                   out_free;

    fat12ccw_table #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_word (tbl_word)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sic_inc  = sic_reg + 8'd1;

    // even cluster keeps the low 12 bits, odd one the high 12
    assign next_cl   = cluster_reg[0] ? tbl_word[15:4] : (tbl_word[11:0] & CLUSTER_MASK);
    assign cl_off    = {{(LBA_W-CLUSTER_W){1'b0}}, cluster_reg} - FIRST_DATA_CL;
    // LBA math wraps at 32 bits, so only the low product bits are kept
    assign prod_full = cl_off * {{(LBA_W-8){1'b0}}, spc_reg};

    always_comb begin
        state_next        = state_reg;
        spc_next          = spc_reg;
        data_start_next   = data_start_reg;
        root_dir_next     = root_dir_reg;
        cluster_next      = cluster_reg;
        sic_next          = sic_reg;
        root_mode_next    = root_mode_reg;
        root_lba_next     = root_lba_reg;
        prod_next         = prod_reg;
        res_valid_next    = res_valid_reg;
        res_lba_next      = res_lba_reg;
        res_end_next      = res_end_reg;
        m_valid_next      = m_valid_reg;
        m_read_valid_next = m_read_valid_reg;
        m_lba_next        = m_lba_reg;
        m_end_next        = m_end_reg;

        tbl_wr.en    = 1'b0;
        tbl_wr.index = s_table_index;
        tbl_wr.data  = s_table_byte;
        tbl_rd.en    = 1'b0;
        // cluster * 3 / 2
        tbl_rd.at    = {1'b0, cluster_reg} + {2'b00, cluster_reg[CLUSTER_W-1:1]};

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SECTORS_PER_CLUSTER: spc_next        = cfg_wdata[7:0];
                REG_DATA_START_LBA:      data_start_next = cfg_wdata;
                REG_ROOT_DIR_LBA:        root_dir_next   = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_WRITE_BYTE: begin
                            tbl_wr.en      = 1'b1;
                            res_valid_next = 1'b0;
                            res_lba_next   = '0;
                            res_end_next   = 1'b0;
                            state_next     = S_DONE;
                        end
                        CMD_OPEN_FILE: begin
                            cluster_next   = s_first_cluster;
                            sic_next       = 8'd0;
                            root_mode_next = 1'b0;
                            state_next     = S_MUL;
                        end
                        CMD_OPEN_ROOT: begin
                            root_mode_next = 1'b1;
                            root_lba_next  = root_dir_reg;
                            res_valid_next = 1'b1;
                            res_lba_next   = root_dir_reg;
                            res_end_next   = 1'b0;
                            state_next     = S_DONE;
                        end
                        default: begin  // advance
                            if (root_mode_reg) begin
                                root_lba_next  = root_lba_reg + 32'd1;
                                res_valid_next = 1'b1;
                                res_lba_next   = root_lba_reg + 32'd1;
                                res_end_next   = 1'b0;
                                state_next     = S_DONE;
                            end else if (sic_inc >= spc_reg) begin
                                // cluster used up: fetch the next link
                                sic_next   = 8'd0;
                                tbl_rd.en  = 1'b1;
                                state_next = S_LOOKUP;
                            end else begin
                                sic_next = sic_inc;
                                if (cluster_reg >= CHAIN_END_MIN) begin
                                    res_valid_next = 1'b0;
                                    res_lba_next   = '0;
                                    res_end_next   = 1'b1;
                                    state_next     = S_DONE;
                                end else begin
                                    state_next = S_MUL;
                                end
                            end
                        end
                    endcase
                end
            end
            S_LOOKUP: begin
                cluster_next = next_cl;
                if (next_cl >= CHAIN_END_MIN) begin
                    res_valid_next = 1'b0;
                    res_lba_next   = '0;
                    res_end_next   = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = prod_full;
                state_next = S_ADD;
            end
            S_ADD: begin
                res_valid_next = 1'b1;
                res_lba_next   = data_start_reg + prod_reg
                               + {{(LBA_W-8){1'b0}}, sic_reg};
                res_end_next   = 1'b0;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_read_valid_next = res_valid_reg;
                    m_lba_next        = res_lba_reg;
                    m_end_next        = res_end_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            spc_reg        <= 8'd1;
            data_start_reg <= '0;
            root_dir_reg   <= '0;
            cluster_reg    <= '0;
            sic_reg        <= 8'd0;
            root_mode_reg  <= 1'b0;
            root_lba_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            spc_reg        <= spc_next;
            data_start_reg <= data_start_next;
            root_dir_reg   <= root_dir_next;
            cluster_reg    <= cluster_next;
            sic_reg        <= sic_next;
            root_mode_reg  <= root_mode_next;
            root_lba_reg   <= root_lba_next;
            m_valid_reg    <= m_valid_next;
        end
        prod_reg         <= prod_next;
        res_valid_reg    <= res_valid_next;
        res_lba_reg      <= res_lba_next;
        res_end_reg      <= res_end_next;
        m_read_valid_reg <= m_read_valid_next;
        m_lba_reg        <= m_lba_next;
        m_end_reg        <= m_end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_valid = m_read_valid_reg;
    assign m_sector_lba = m_lba_reg;
    assign m_chain_end  = m_end_reg;

    // ---- checks ----
    `FCW_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second command taken while busy")
    `FCW_ASSERT_IMPLY(a_end_not_read, m_valid && m_chain_end, !m_read_valid, "chain end with a read")
    `FCW_ASSERT_IMPLY(a_lba_zero, m_valid && !m_read_valid, m_sector_lba == 32'd0, "LBA not zero")
    `FCW_ASSERT_NEXT(a_lookup_follows, state_reg == S_IDLE && tbl_rd.en, state_reg == S_LOOKUP, "table read without lookup")

endmodule
